/* rtl/core/pwm_envelope_shaper_defines.svh */
// Assertion macros shared by the checker of the PWM envelope shaper.
// No dependencies; the user must have clk_i and rst_ni in scope.
`ifndef PWM_ENVELOPE_SHAPER_DEFINES_SVH
`define PWM_ENVELOPE_SHAPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PES_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pes_pkg.sv */
// Package of the PWM envelope shaper: constants, fixed-point gains and the
// sideband struct that travels with each sample. No dependencies.
`default_nettype none

package pes_pkg;

  // Default phase resolution in bits (Q0.PHASE_BITS).
  localparam int unsigned PES_PHASE_BITS = 16;

  // Widths of the stream payloads.
  localparam int unsigned PES_S_TDATA_W = 48;
  localparam int unsigned PES_M_TDATA_W = 16;

  // Pulse width arithmetic in Q0.24.
  localparam int unsigned PES_WIDTH_BITS = 24;
  localparam int unsigned PES_WIDTH_GAIN = 8053064;
  localparam int unsigned PES_WIDTH_HALF = 8388608;
  localparam int unsigned PES_WIDTH_MIN  = 335544;
  localparam int unsigned PES_WIDTH_MAX  = 16441672;

  // Quotient resolution and how the divider is spread over stages.
  localparam int unsigned PES_Q_BITS     = 16;
  localparam int unsigned PES_DIV_STEP   = 2;
  localparam int unsigned PES_DIV_STAGES = PES_Q_BITS / PES_DIV_STEP;

  // Saturation limits of the output level.
  localparam logic signed [15:0] PES_LEVEL_MAX = 16'sd32767;
  localparam logic signed [15:0] PES_LEVEL_MIN = -16'sd32767;

  // Segment information carried alongside the divider.
  typedef struct packed {
    logic on;    // phase lies in the on-time
    logic done;  // ramp finished or absent: level is a hard rail
  } pes_side_t;

endpackage

`default_nettype wire

/* rtl/core/pes_front.sv */
// Front stages of the PWM envelope shaper: pulse width from shape, then the
// ramp length and time into the segment. Depends on pes_pkg.
`default_nettype none

module pes_front #(
  parameter int unsigned PHASE_BITS = pes_pkg::PES_PHASE_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [15:0]             phase_i,
  input  wire logic signed [15:0]      shape_i,
  input  wire logic signed [15:0]      mod_i,
  output logic                         valid_o,
  output logic [PHASE_BITS-1:0]        t_o,
  output logic [PHASE_BITS-1:0]        len_o,
  output pes_pkg::pes_side_t           side_o
);
  import pes_pkg::*;

  localparam int PB     = PHASE_BITS;
  localparam int SH     = int'(PES_WIDTH_BITS) - PB;
  localparam int PRODW  = 16 + PB;
  localparam logic signed [23:0] GAIN = 24'(PES_WIDTH_GAIN);
  localparam logic signed [39:0] W_HALF = $signed(40'(PES_WIDTH_HALF));
  localparam logic signed [39:0] W_MIN  = $signed(40'(PES_WIDTH_MIN));
  localparam logic signed [39:0] W_MAX  = $signed(40'(PES_WIDTH_MAX));
  localparam logic [24:0] HALF_RND = (SH == 0) ? 25'd0 : (25'd1 << (SH - 1));
  localparam logic [PB:0] FULL = (PB+1)'(1) << PB;

  // Stage one: shape times the width gain.
  logic                    s1_v_q;
  logic signed [39:0]      s1_prod_q;
  logic [PB-1:0]           s1_ph_q;
  logic signed [15:0]      s1_mod_q;

  // Stage two: pulse width in Q0.PHASE_BITS.
  logic                    s2_v_q;
  logic [PB-1:0]           s2_width_q;
  logic [PB-1:0]           s2_ph_q;
  logic signed [15:0]      s2_mod_q;
  logic signed [39:0]      w_rnd;
  logic [23:0]             w24;
  logic [24:0]             w_sum;
  logic [PB-1:0]           width_d;

  // Stage three: segment select and ramp length product.
  logic                    s3_v_q;
  logic [PRODW-1:0]        s3_prod_q;
  logic [PB-1:0]           s3_t_q;
  logic                    s3_on_q;
  logic                    on_d;
  logic [PB-1:0]           t_d;
  logic [PB-1:0]           seg_d;
  logic [15:0]             mag_d;
  logic [PB:0]             rest;

  // Stage four: ramp length and rail detection.
  logic [PB-1:0]           len_d;

  // Width: round the Q0.24 product, add one half, clamp, round to phase bits.
  always_comb begin
    w_rnd = ((s1_prod_q + 40'sd16384) >>> 15) + W_HALF;
    if (w_rnd < W_MIN) begin
      w24 = 24'(PES_WIDTH_MIN);
    end else if (w_rnd > W_MAX) begin
      w24 = 24'(PES_WIDTH_MAX);
    end else begin
      w24 = w_rnd[23:0];
    end
    w_sum   = {1'b0, w24} + HALF_RND;
    width_d = PB'(w_sum >> SH);
  end

  // Segment: on-time uses the rise, off-time uses the fall of the rest.
  always_comb begin
    rest  = FULL - {1'b0, s2_width_q};
    on_d  = s2_ph_q < s2_width_q;
    t_d   = on_d ? s2_ph_q : s2_ph_q - s2_width_q;
    seg_d = on_d ? s2_width_q : rest[PB-1:0];
    mag_d = '0;
    if (on_d && !s2_mod_q[15] && (s2_mod_q != 16'sd0)) begin
      mag_d = s2_mod_q;
    end else if (!on_d && s2_mod_q[15]) begin
      mag_d = 16'(-s2_mod_q);
    end
  end

  assign len_d = PB'(s3_prod_q >> 15);

  // Valid bits of the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      s1_v_q  <= valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      valid_o <= s3_v_q;
    end
  end

  // Payload of the four stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_prod_q   <= 40'(shape_i) * 40'(GAIN);
      s1_ph_q     <= PB'(phase_i);
      s1_mod_q    <= mod_i;
      s2_width_q  <= width_d;
      s2_ph_q     <= s1_ph_q;
      s2_mod_q    <= s1_mod_q;
      s3_prod_q   <= PRODW'(mag_d) * PRODW'(seg_d);
      s3_t_q      <= t_d;
      s3_on_q     <= on_d;
      t_o         <= s3_t_q;
      len_o       <= len_d;
      side_o.on   <= s3_on_q;
      side_o.done <= s3_t_q >= len_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pes_div.sv */
// Pipelined restoring divider of the PWM envelope shaper: (t << 16) / len
// with t below len, two quotient bits per stage. Depends on pes_pkg.
`default_nettype none

module pes_div #(
  parameter int unsigned PHASE_BITS = pes_pkg::PES_PHASE_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [PHASE_BITS-1:0]       t_i,
  input  wire logic [PHASE_BITS-1:0]       len_i,
  input  wire pes_pkg::pes_side_t          side_i,
  output logic                             valid_o,
  output logic [pes_pkg::PES_Q_BITS-1:0]   quo_o,
  output pes_pkg::pes_side_t               side_o
);
  import pes_pkg::*;

  localparam int PB = PHASE_BITS;
  localparam int NS = PES_DIV_STAGES;

  logic [NS-1:0]       v_q;
  logic [PB-1:0]       rem_q  [NS];
  logic [PB-1:0]       len_q  [NS];
  logic [PES_Q_BITS-1:0] quo_q [NS];
  pes_side_t           side_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic            v_in;
    logic [PB-1:0]   rem_in;
    logic [PB-1:0]   len_in;
    logic [PES_Q_BITS-1:0] quo_in;
    pes_side_t       side_in;
    logic [PB-1:0]   rem_d;
    logic [PES_Q_BITS-1:0] quo_d;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = t_i;
      assign len_in  = len_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign len_in  = len_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Shift-and-subtract steps of this stage.
    always_comb begin
      logic [PB:0] shifted;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int k = 0; k < int'(PES_DIV_STEP); k++) begin
        shifted = {rem_d, 1'b0};
        if (shifted >= {1'b0, len_in}) begin
          rem_d = PB'(shifted - {1'b0, len_in});
          quo_d = {quo_d[PES_Q_BITS-2:0], 1'b1};
        end else begin
          rem_d = PB'(shifted);
          quo_d = {quo_d[PES_Q_BITS-2:0], 1'b0};
        end
      end
    end

    // Stage valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    // Stage payload.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        len_q[g]  <= len_in;
        quo_q[g]  <= quo_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

/* rtl/core/pes_back.sv */
// Back stage of the PWM envelope shaper: squares the distance to the ramp
// end and forms the saturated level. Depends on pes_pkg.
`default_nettype none

module pes_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [pes_pkg::PES_Q_BITS-1:0] quo_i,
  input  wire pes_pkg::pes_side_t          side_i,
  output logic                             valid_o,
  output logic signed [15:0]               level_o
);
  import pes_pkg::*;

  logic [PES_Q_BITS:0]     remain;
  logic [33:0]             sq_q;
  pes_side_t               side_q;
  logic [16:0]             sq_rnd;
  logic signed [17:0]      lv;

  assign remain = 17'd65536 - {1'b0, quo_i};

  // Square register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= 34'(remain) * 34'(remain);
      side_q <= side_i;
    end
  end

  // Round the square to Q0.16, place it on the rail and saturate.
  always_comb begin
    sq_rnd = 17'((sq_q + 34'd32768) >> 16);
    if (side_q.on) begin
      lv = 18'sd32768 - $signed({1'b0, sq_rnd});
    end else begin
      lv = $signed({1'b0, sq_rnd}) - 18'sd32768;
    end
    if (side_q.done) begin
      level_o = side_q.on ? PES_LEVEL_MAX : PES_LEVEL_MIN;
    end else if (lv > 18'sd32767) begin
      level_o = PES_LEVEL_MAX;
    end else if (lv < -18'sd32767) begin
      level_o = PES_LEVEL_MIN;
    end else begin
      level_o = lv[15:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pwm_envelope_shaper.sv */
// PWM envelope shaper: one input stream of (phase, shape, mod), one output
// stream of levels. Top level; uses pes_pkg, pes_front, pes_div, pes_back.
//
// Usage:
//   Each input transaction carries an oscillator phase, a shape value that
//   sets the pulse width and a mod value that sets a curved attack (positive)
//   or decay (negative). Each one gives exactly one output transaction with
//   the bipolar level in Q1.15, in the order of the inputs.
//   The pipeline holds four width and edge-length stages, eight divider
//   stages at two quotient bits each, one squaring stage and the output
//   register. The divider chain sets most of the depth. The whole chain
//   is pipelined, so throughput is one transaction per cycle while the
//   receiver keeps up.
//   The output register is backed by a skid register, so when the receiver
//   stalls the last sample in flight is parked and s_axis_tready drops in the
//   next cycle; it rises again in the cycle after the receiver takes data.
//   Reset empties every stage; no transaction is in flight afterwards and
//   s_axis_tready is high.
`default_nettype none

module pwm_envelope_shaper #(
  parameter int unsigned PHASE_BITS = pes_pkg::PES_PHASE_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] phase, [31:16] shape, [47:32] mod
  input  wire logic [pes_pkg::PES_S_TDATA_W-1:0]  s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [15:0] level
  output logic [pes_pkg::PES_M_TDATA_W-1:0]       m_axis_tdata
);
  import pes_pkg::*;

  logic                     en;
  logic                     front_v;
  logic [PHASE_BITS-1:0]    front_t;
  logic [PHASE_BITS-1:0]    front_len;
  pes_side_t                front_side;
  logic                     div_v;
  logic [PES_Q_BITS-1:0]    div_quo;
  pes_side_t                div_side;
  logic                     back_v;
  logic signed [15:0]       back_level;
  logic                     out_v_q;
  logic [15:0]              out_data_q;
  logic                     skid_v_q;
  logic [15:0]              skid_data_q;
  logic                     out_take;
  logic                     pipe_v;

  // The pipeline advances unless a sample is parked in the skid register.
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  pes_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .phase_i (s_axis_tdata[15:0]),
    .shape_i (s_axis_tdata[31:16]),
    .mod_i   (s_axis_tdata[47:32]),
    .valid_o (front_v),
    .t_o     (front_t),
    .len_o   (front_len),
    .side_o  (front_side)
  );

  pes_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .t_i     (front_t),
    .len_i   (front_len),
    .side_i  (front_side),
    .valid_o (div_v),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  pes_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_v),
    .quo_i   (div_quo),
    .side_i  (div_side),
    .valid_o (back_v),
    .level_o (back_level)
  );

  // A finished sample leaves the pipeline whenever it advances.
  assign out_take = !out_v_q || m_axis_tready;
  assign pipe_v   = back_v && en;

  // Output and skid valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pipe_v;
      end
    end else if (pipe_v) begin
      skid_v_q <= 1'b1;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_data_q <= skid_v_q ? skid_data_q : back_level;
    end else if (pipe_v) begin
      skid_data_q <= back_level;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/core/pes_checker.sv */
// Port-level checker of the PWM envelope shaper and its bind statement.
// Depends on pwm_envelope_shaper_defines.svh and the top level.
`default_nettype none

`include "pwm_envelope_shaper_defines.svh"

module pes_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A stalled output transaction keeps its level.
  `PES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

  // The level is saturated symmetrically and never shows the most negative code.
  `PES_ASSERT_SAME(a_level_range, m_axis_tvalid, m_axis_tdata != 16'h8000, "level out of range")

  // The input side only backs up after the receiver held off a valid output.
  `PES_ASSERT_SAME(a_ready_cause, !s_axis_tready, $past(m_axis_tvalid && !m_axis_tready), "input stalled without output stall")

  // A receiver that was ready frees the input side in the next cycle.
  `PES_ASSERT_SAME(a_ready_release, $past(m_axis_tready), s_axis_tready, "input still stalled after output drained")

endmodule

bind pwm_envelope_shaper pes_checker u_pes_checker (.*);

`default_nettype wire
